// ----- src/epmsc_pkg.sv -----
package epmsc_pkg;

	// item field widths
	localparam int OP_W    = 2;
	localparam int POT_W   = 12;
	localparam int DUTY_W  = 8;
	localparam int MRPM_W  = 10;
	localparam int DRPM_W  = 9;

	// state and register widths
	localparam int CNT_W   = 16;
	localparam int LATCH_W = 17;
	localparam int ACC_W   = 40;
	localparam int MODE_W  = 2;
	localparam int GAIN_W  = 8;
	localparam int SCALE_W = 16;
	localparam int Q6_W    = 16;
	localparam int ERR_W   = Q6_W + 2;

	// input op codes
	localparam logic [OP_W-1:0] OP_ENC_A = 2'd0;
	localparam logic [OP_W-1:0] OP_ENC_B = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
	localparam logic [OP_W-1:0] OP_CTRL  = 2'd3;

	localparam logic [MODE_W-1:0] MODE_OPEN = 2'd0;

	// APB register map, 4-byte stride
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_LOOP_MODE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SPIN_DIR    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PROP_STEPS  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_INTEG_STEPS = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RPM_SCALE   = 3'd4;

	localparam logic [MODE_W-1:0]  RST_LOOP_MODE   = 2'd0;
	localparam logic               RST_SPIN_DIR    = 1'b1;
	localparam logic [GAIN_W-1:0]  RST_PROP_STEPS  = 8'd5;
	localparam logic [GAIN_W-1:0]  RST_INTEG_STEPS = 8'd5;
	localparam logic [SCALE_W-1:0] RST_RPM_SCALE   = 16'd2053;

	// defaults for the top level parameters
	localparam int unsigned DEF_PWM_PERIOD = 240;
	localparam int unsigned DEF_MAX_RPM    = 350;
	localparam int unsigned DEF_ADC_BITS   = 12;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic               dir;
		logic [GAIN_W-1:0]  prop;
		logic [GAIN_W-1:0]  integ;
		logic [SCALE_W-1:0] scale;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic inc_a;
		logic inc_b;
		logic tick;
		logic capture;
		logic calc_meas;
		logic upd_acc;
		logic calc_terms;
		logic calc_sum;
		logic calc_num;
		logic div_init;
		logic div_step;
		logic div_fin;
		logic ld_out;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pending;
		logic open_loop;
	} dp_sts_t;

endpackage

// ----- src/epmsc_in_if.sv -----
interface epmsc_in_if;
	import epmsc_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [POT_W-1:0]  pot_sample;

	modport source(output valid, op, pot_sample, input ready);
	modport sink(input valid, op, pot_sample, output ready);
endinterface

// ----- src/epmsc_out_if.sv -----
interface epmsc_out_if;
	import epmsc_pkg::*;

	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty;
	logic [MRPM_W-1:0] measured_rpm;
	logic [DRPM_W-1:0] desired_rpm;
	logic              bridge_in1;
	logic              bridge_in2;

	modport source(output valid, duty, measured_rpm, desired_rpm, bridge_in1, bridge_in2,
		input ready);
	modport sink(input valid, duty, measured_rpm, desired_rpm, bridge_in1, bridge_in2,
		output ready);
endinterface

// ----- src/epmsc_cfg.sv -----
module epmsc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [epmsc_pkg::PADDR_W-1:0]   paddr,
	input  logic [epmsc_pkg::PDATA_W-1:0]   pwdata,
	output logic [epmsc_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	output epmsc_pkg::cfg_t                 cfg
);
	import epmsc_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= RST_LOOP_MODE;
			cfg_q.dir   <= RST_SPIN_DIR;
			cfg_q.prop  <= RST_PROP_STEPS;
			cfg_q.integ <= RST_INTEG_STEPS;
			cfg_q.scale <= RST_RPM_SCALE;
		end else if (wr_en) begin
			case (idx)
				REG_LOOP_MODE:   cfg_q.mode  <= pwdata[MODE_W-1:0];
				REG_SPIN_DIR:    cfg_q.dir   <= pwdata[0];
				REG_PROP_STEPS:  cfg_q.prop  <= pwdata[GAIN_W-1:0];
				REG_INTEG_STEPS: cfg_q.integ <= pwdata[GAIN_W-1:0];
				REG_RPM_SCALE:   cfg_q.scale <= pwdata[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LOOP_MODE:   prdata = PDATA_W'(cfg_q.mode);
			REG_SPIN_DIR:    prdata = PDATA_W'(cfg_q.dir);
			REG_PROP_STEPS:  prdata = PDATA_W'(cfg_q.prop);
			REG_INTEG_STEPS: prdata = PDATA_W'(cfg_q.integ);
			REG_RPM_SCALE:   prdata = PDATA_W'(cfg_q.scale);
			default:         prdata = '0;
		endcase
	end
endmodule

// ----- src/epmsc_ctrl.sv -----
module epmsc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [epmsc_pkg::OP_W-1:0]    in_op,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  epmsc_pkg::dp_sts_t            sts,
	output epmsc_pkg::dp_cmd_t            cmd
);
	import epmsc_pkg::*;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE = 4'd0;
	localparam logic [ST_W-1:0] S_MEAS = 4'd1;
	localparam logic [ST_W-1:0] S_ACC  = 4'd2;
	localparam logic [ST_W-1:0] S_TERM = 4'd3;
	localparam logic [ST_W-1:0] S_SUM  = 4'd4;
	localparam logic [ST_W-1:0] S_NUM  = 4'd5;
	localparam logic [ST_W-1:0] S_DIVI = 4'd6;
	localparam logic [ST_W-1:0] S_DIV  = 4'd7;
	localparam logic [ST_W-1:0] S_FIN  = 4'd8;
	localparam logic [ST_W-1:0] S_OUT  = 4'd9;

	logic [ST_W-1:0]   state_q, state_d;
	logic              out_valid_q;
	logic              slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_op)
						OP_ENC_A: cmd.inc_a = 1'b1;
						OP_ENC_B: cmd.inc_b = 1'b1;
						OP_TICK:  cmd.tick  = 1'b1;
						OP_CTRL: begin
							// no tick since last result: request is dropped
							if (sts.pending) begin
								cmd.capture = 1'b1;
								state_d     = S_MEAS;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_MEAS: begin
				cmd.calc_meas = 1'b1;
				state_d       = sts.open_loop ? S_OUT : S_ACC;
			end
			S_ACC: begin
				cmd.upd_acc = 1'b1;
				state_d     = S_TERM;
			end
			S_TERM: begin
				cmd.calc_terms = 1'b1;
				state_d        = S_SUM;
			end
			S_SUM: begin
				cmd.calc_sum = 1'b1;
				state_d      = S_NUM;
			end
			S_NUM: begin
				cmd.calc_num = 1'b1;
				state_d      = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				// reciprocal multiply
				cmd.div_step = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				cmd.div_fin = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (slot_free) begin
					cmd.ld_out = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

// ----- src/epmsc_dp.sv -----
module epmsc_dp #(
	parameter int unsigned PWM_PERIOD = epmsc_pkg::DEF_PWM_PERIOD,
	parameter int unsigned MAX_RPM    = epmsc_pkg::DEF_MAX_RPM,
	parameter int unsigned ADC_BITS   = epmsc_pkg::DEF_ADC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  epmsc_pkg::cfg_t                cfg,
	input  epmsc_pkg::dp_cmd_t             cmd,
	output epmsc_pkg::dp_sts_t             sts,
	input  logic [epmsc_pkg::POT_W-1:0]    pot_sample,
	output logic [epmsc_pkg::DUTY_W-1:0]   duty,
	output logic [epmsc_pkg::MRPM_W-1:0]   measured_rpm,
	output logic [epmsc_pkg::DRPM_W-1:0]   desired_rpm,
	output logic                           bridge_in1,
	output logic                           bridge_in2
);
	import epmsc_pkg::*;

	localparam int unsigned TOP      = (PWM_PERIOD < 255) ? PWM_PERIOD : 255;
	localparam int unsigned POT_MAX  = (1 << ADC_BITS) - 1;
	localparam int RPM_W       = $clog2(MAX_RPM + 1);
	localparam int PER_W       = $clog2(PWM_PERIOD + 1);
	localparam int DES_PROD_W  = POT_W + RPM_W + 6;
	localparam int OPEN_PROD_W = POT_W + PER_W;
	localparam int MEAS_PROD_W = LATCH_W + SCALE_W;
	localparam int KP_W        = GAIN_W + 7;
	localparam int unsigned KP_SCALE = 100;
	localparam int P_W         = KP_W + 1 + ERR_W;
	localparam int I_W         = GAIN_W + 1 + ACC_W;
	localparam int S_W         = I_W + 1;
	localparam int NUM_W       = S_W + PER_W + 1;
	localparam longint unsigned DEN      = 64'(64000) * 64'(MAX_RPM);
	localparam longint unsigned HALF_DEN = DEN / 2;
	localparam longint unsigned SAT_LIM  = 64'(TOP + 1) * DEN;
	localparam logic signed [NUM_W-1:0] PER_S = NUM_W'(PWM_PERIOD);

	// 64000 = 2^9 * 125: shift out the power of two, then multiply by a
	// reciprocal of the odd part. Below the saturation limit the shifted
	// value fits Y_W bits, and a reciprocal rounded up with RCP_SH =
	// Y_W + log2(divisor) fraction bits gives the exact floor.
	localparam int DEN_SHIFT = 9;
	localparam longint unsigned DEN_ODD = 64'(125) * 64'(MAX_RPM);
	localparam int Y_W         = $clog2(64'(TOP + 1) * DEN_ODD);
	localparam int ODD_W       = $clog2(DEN_ODD);
	localparam int RCP_SH      = Y_W + ODD_W;
	localparam int RCP_W       = Y_W + 1;
	localparam int PROD_W      = Y_W + RCP_W;
	localparam longint unsigned RCP_VAL = ((64'd1 << RCP_SH) + DEN_ODD - 1) / DEN_ODD;
	localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);

	// encoder and period state
	logic [CNT_W-1:0]   count_a_q, count_b_q;
	logic [LATCH_W-1:0] latched_q;
	logic               pending_q;
	logic signed [ACC_W-1:0] acc_q;

	// working registers
	logic [POT_W-1:0]        pot_q;
	logic [Q6_W-1:0]         des_q6_q, meas_q6_q;
	logic [DUTY_W-1:0]       duty_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [P_W-1:0]   p_q;
	logic signed [I_W-1:0]   i_q;
	logic signed [S_W-1:0]   s_q;
	logic signed [NUM_W-1:0] num_q;
	logic [Y_W-1:0]          y_q;
	logic [PROD_W-1:0]       prod_q;
	logic                    pos_q, sat_q;

	// output register
	logic [DUTY_W-1:0] duty_o_q;
	logic [MRPM_W-1:0] mrpm_o_q;
	logic [DRPM_W-1:0] drpm_o_q;
	logic              in1_o_q, in2_o_q;

	logic [POT_W-1:0]        pot_sat;
	logic [DES_PROD_W-1:0]   des_prod;
	logic [OPEN_PROD_W-1:0]  open_prod, open_whole;
	logic [MEAS_PROD_W-1:0]  meas_prod;
	logic [Q6_W-1:0]         meas_sat;
	logic [DUTY_W-1:0]       open_duty;
	logic signed [ERR_W-1:0] err;
	logic [ACC_W:0]          acc_sum;
	logic signed [ACC_W-1:0] acc_new;
	logic [KP_W-1:0]         kp100;
	logic signed [P_W-1:0]   p_prod;
	logic signed [I_W-1:0]   i_prod;
	logic signed [NUM_W-1:0] num_full;
	logic [NUM_W-1:0]        x_val;

	function automatic logic [DRPM_W-1:0] meas_or_des_sat(input logic [Q6_W-1:0] q6);
		return q6[Q6_W-1] ? '1 : q6[Q6_W-2:6];
	endfunction

	assign sts.pending   = pending_q;
	assign sts.open_loop = (cfg.mode == MODE_OPEN);

	assign pot_sat = (32'(pot_sample) > POT_MAX) ? POT_W'(POT_MAX) : pot_sample;

	// speed terms, Q10.6
	assign des_prod   = DES_PROD_W'(pot_q) * DES_PROD_W'(MAX_RPM * 64);
	assign open_prod  = OPEN_PROD_W'(pot_q) * OPEN_PROD_W'(PWM_PERIOD);
	assign open_whole = open_prod >> ADC_BITS;
	assign open_duty  = (open_whole > OPEN_PROD_W'(TOP)) ? DUTY_W'(TOP) : DUTY_W'(open_whole);
	assign meas_prod  = MEAS_PROD_W'(latched_q) * MEAS_PROD_W'(cfg.scale);
	assign meas_sat   = (meas_prod[MEAS_PROD_W-1:Q6_W+2] != '0) ? '1 : meas_prod[Q6_W+1:2];

	// error and saturating accumulator
	assign err     = $signed({2'b00, des_q6_q}) - $signed({2'b00, meas_q6_q});
	assign acc_sum = {acc_q[ACC_W-1], acc_q} + {{(ACC_W + 1 - ERR_W){err[ERR_W-1]}}, err};
	always_comb begin
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
			acc_new = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		else
			acc_new = acc_sum[ACC_W-1:0];
	end

	// PI terms
	assign kp100    = KP_W'(cfg.prop) * KP_W'(KP_SCALE);
	assign p_prod   = $signed({1'b0, kp100}) * err_q;
	assign i_prod   = $signed({1'b0, cfg.integ}) * acc_q;
	assign num_full = $signed({{(NUM_W-S_W){s_q[S_W-1]}}, s_q}) * PER_S;

	// rounding offset ahead of the divide
	assign x_val = $unsigned(num_q) + NUM_W'(HALF_DEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= '0;
			count_b_q <= '0;
			latched_q <= '0;
			pending_q <= 1'b0;
			acc_q     <= '0;
		end else begin
			if (cmd.inc_a && (count_a_q != '1)) count_a_q <= count_a_q + 1'b1;
			if (cmd.inc_b && (count_b_q != '1)) count_b_q <= count_b_q + 1'b1;
			if (cmd.tick) begin
				latched_q <= LATCH_W'(count_a_q) + LATCH_W'(count_b_q);
				count_a_q <= '0;
				count_b_q <= '0;
				pending_q <= 1'b1;
			end
			if (cmd.capture)   pending_q <= 1'b0;
			if (cmd.calc_meas) latched_q <= '0;
			if (cmd.upd_acc)   acc_q     <= acc_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) pot_q <= pot_sat;
		if (cmd.calc_meas) begin
			des_q6_q  <= Q6_W'(des_prod >> ADC_BITS);
			meas_q6_q <= meas_sat;
			duty_q    <= open_duty;
		end
		if (cmd.upd_acc) err_q <= err;
		if (cmd.calc_terms) begin
			p_q <= p_prod;
			i_q <= i_prod;
		end
		if (cmd.calc_sum)
			s_q <= {{(S_W-P_W){p_q[P_W-1]}}, p_q} + {{(S_W-I_W){i_q[I_W-1]}}, i_q};
		if (cmd.calc_num) num_q <= num_full;
		if (cmd.div_init) begin
			pos_q <= !num_q[NUM_W-1] && (num_q != '0);
			sat_q <= (x_val >= NUM_W'(SAT_LIM));
			y_q   <= Y_W'(x_val >> DEN_SHIFT);
		end
		if (cmd.div_step) prod_q <= PROD_W'(y_q) * PROD_W'(RCP);
		if (cmd.div_fin)
			duty_q <= !pos_q ? '0 : (sat_q ? DUTY_W'(TOP) : DUTY_W'(prod_q >> RCP_SH));
		if (cmd.ld_out) begin
			duty_o_q <= duty_q;
			mrpm_o_q <= meas_q6_q[Q6_W-1:6];
			drpm_o_q <= meas_or_des_sat(des_q6_q);
			in1_o_q  <= !cfg.dir;
			in2_o_q  <= cfg.dir;
		end
	end

	assign duty         = duty_o_q;
	assign measured_rpm = mrpm_o_q;
	assign desired_rpm  = drpm_o_q;
	assign bridge_in1   = in1_o_q;
	assign bridge_in2   = in2_o_q;
endmodule

// ----- src/encoder_pi_motor_speed_control.sv -----
// Channel   Dir  Handshake       Payload
// in_ch     in   valid/ready     op, pot_sample
// out_ch    out  valid/ready     duty, measured_rpm, desired_rpm, bridge_in1, bridge_in2
// apb       in   psel/penable    paddr, pwdata -> prdata, pready tied high
//
// Sequencing: an encoder edge, a period tick or a request with no tick pending
// is handled in the idle state. An open-loop request steps through measure and
// output; a closed-loop request also runs the PI pipeline steps and the
// reciprocal multiply that turns the rounded PI sum into a duty value.
// Reset: arst_n clears counters, the latch, the pending flag, the accumulator
// and the config registers to their documented values.
// Stalls: in_ch is taken only while the sequencer is idle. A held result in the
// output register alone leaves edges and ticks flowing; the next result then
// waits in the sequencer and holds in_ch off until the register frees.
module encoder_pi_motor_speed_control #(
	parameter int unsigned PWM_PERIOD = epmsc_pkg::DEF_PWM_PERIOD,
	parameter int unsigned MAX_RPM    = epmsc_pkg::DEF_MAX_RPM,
	parameter int unsigned ADC_BITS   = epmsc_pkg::DEF_ADC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	epmsc_in_if.sink                      in_ch,
	epmsc_out_if.source                   out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [epmsc_pkg::PADDR_W-1:0] paddr,
	input  logic [epmsc_pkg::PDATA_W-1:0] pwdata,
	output logic [epmsc_pkg::PDATA_W-1:0] prdata,
	output logic                          pready
);
	import epmsc_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	// register file: loop mode, direction, gains, RPM scale
	epmsc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: decodes ops, steps the PI pipeline and divide, owns out valid
	epmsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_op     (in_ch.op),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: pulse counters, Q10.6 speed math, saturating integrator,
	// PI sum times period, rounding divide by 64000*MAX_RPM, output register
	epmsc_dp #(
		.PWM_PERIOD (PWM_PERIOD),
		.MAX_RPM    (MAX_RPM),
		.ADC_BITS   (ADC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.pot_sample   (in_ch.pot_sample),
		.duty         (out_ch.duty),
		.measured_rpm (out_ch.measured_rpm),
		.desired_rpm  (out_ch.desired_rpm),
		.bridge_in1   (out_ch.bridge_in1),
		.bridge_in2   (out_ch.bridge_in2)
	);
endmodule
